// ===== sv/four_state_integer_alu_defines.svh =====
// assertion macros for the four-state alu
`ifndef FOUR_STATE_INTEGER_ALU_DEFINES_SVH
`define FOUR_STATE_INTEGER_ALU_DEFINES_SVH

// implication checked on every clock edge outside reset
`define FSA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define FSA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/fsa_pkg.sv =====
package fsa_pkg;
    localparam int unsigned DataWidthDefault = 64;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_AND  = 4'd4,
        OP_OR   = 4'd5,
        OP_XOR  = 4'd6,
        OP_SHL  = 4'd7,
        OP_LSHR = 4'd8,
        OP_ASHR = 4'd9
    } t_opcode;
endpackage

// ===== sv/four_state_integer_alu.sv =====
// Four-state integer ALU. One item carries an opcode, a width of 1 to 64 bits
// and two operands, each a value word and an unknown word (1 marks X or Z),
// and gives one result item: result and, for divide, remainder. Add, sub, the
// bitwise ops, undefined opcodes and any all-unknown result go from the
// prepare state straight to done; multiply, divide and an in-range shift
// iterate one operand bit per cycle, and divide ends in a sign-fix pass. The
// result is offered on the edge at which the sequencer frees. A result
// waiting under i_stall sits in its own output register, so the next item can
// be taken and worked on meanwhile; the input stalls only while the sequencer
// is busy, including when a second finished result waits for the output
// register. DATA_WIDTH (8..64) bounds the supported operand width; wider
// op_width acts as DATA_WIDTH, and op_width 0 acts as 1.
module four_state_integer_alu #(
    parameter int unsigned DATA_WIDTH = fsa_pkg::DataWidthDefault
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [3:0]            i_opcode,
    input  logic [6:0]            i_op_width,
    input  logic                  i_four_state,
    input  logic                  i_is_signed,
    input  logic [63:0]           i_a_value,
    input  logic [63:0]           i_a_unknown,
    input  logic [63:0]           i_b_value,
    input  logic [63:0]           i_b_unknown,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [63:0]           o_result_value,
    output logic [63:0]           o_result_unknown,
    output logic [63:0]           o_remainder_value,
    output logic [63:0]           o_remainder_unknown
);
    import fsa_pkg::*;
    `include "four_state_integer_alu_defines.svh"

    localparam int unsigned DW = DATA_WIDTH;
    localparam int unsigned CW = $clog2(DW + 1);
    localparam int unsigned IW = $clog2(DW);

    typedef enum logic [2:0] {
        S_IDLE, S_PREP, S_MUL, S_DIV, S_SHIFT, S_FIX, S_DONE
    } t_state;

    t_state         r_state;
    logic [3:0]     r_op;
    logic           r_fs, r_sg;
    logic [CW-1:0]  r_w, r_cnt;
    logic [DW-1:0]  r_mask, r_av, r_au, r_bv, r_bu;
    logic [DW-1:0]  r_acc, r_acu, r_rem;
    logic           r_an, r_bn;
    logic [63:0]    r_rv, r_ru, r_qv, r_qu;

    // output register, holds a result item while the sink stalls
    logic           r_ovalid;
    logic [63:0]    r_out_rv, r_out_ru, r_out_qv, r_out_qu;
    logic           load_out;

    // input capture helpers
    logic [6:0]     w_in;
    logic [DW-1:0]  m_in;
    always_comb begin
        w_in = i_op_width;
        if (w_in == 7'd0) w_in = 7'd1;
        if (w_in > 7'(DW)) w_in = 7'(DW);
        m_in = '1;
        for (int i = 0; i < DW; i++) begin
            if (7'(i) >= w_in) m_in[i] = 1'b0;
        end
    end

    // shared adder: one add of two operand-wide words, with an invert option
    logic [DW-1:0] add_x, add_y, add_s;
    logic          add_ci;
    assign add_s = add_x + (add_y ^ {DW{add_ci}}) + DW'(add_ci);

    logic [DW-1:0] top_bit;
    assign top_bit = r_mask & ~(r_mask >> 1);

    // multiply step: next multiplier bit, from bit op_width-1 down to 0
    logic [IW-1:0] mul_idx;
    logic [DW-1:0] mul_next;
    assign mul_idx  = IW'(r_w - r_cnt - CW'(1));
    assign mul_next = r_av[mul_idx] ? add_s : r_acc;

    // divide step: shift in next dividend bit, trial subtract
    logic [DW:0]   d_trial;
    logic [DW-1:0] d_rsh;
    assign d_rsh   = {r_rem[DW-2:0], r_acc[DW-1]};
    assign d_trial = {r_rem[DW-1], d_rsh} - {1'b0, r_bv};

    // four-state bitwise
    logic [DW-1:0] bw_v, bw_u, ak, bk;
    always_comb begin
        ak = ~r_au;
        bk = ~r_bu;
        bw_v = '0;
        bw_u = '0;
        case (r_op)
            OP_AND: begin
                if (!r_fs) bw_v = r_av & r_bv;
                else begin
                    bw_v = r_av & ak & r_bv & bk;
                    bw_u = ~(((~r_av & ak) | (~r_bv & bk)) | bw_v);
                end
            end
            OP_OR: begin
                if (!r_fs) bw_v = r_av | r_bv;
                else begin
                    bw_v = (r_av & ak) | (r_bv & bk);
                    bw_u = ~(((~r_av & ak) & (~r_bv & bk)) | bw_v);
                end
            end
            default: begin
                if (!r_fs) bw_v = r_av ^ r_bv;
                else begin
                    bw_u = r_au | r_bu;
                    bw_v = (r_av ^ r_bv) & ~bw_u;
                end
            end
        endcase
    end

    always_comb begin
        add_x  = r_av;
        add_y  = r_bv;
        add_ci = 1'b0;
        unique case (r_state)
            S_PREP: begin
                add_ci = (r_op == OP_SUB);
            end
            S_MUL: begin
                add_x = r_acc;
                add_y = r_bv;
            end
            S_FIX: begin
                // negate quotient in fix pass
                add_x = '0;
                add_y = r_acc;
                add_ci = 1'b1;
            end
            default: ;
        endcase
    end

    logic [DW-1:0] neg_av, neg_bv, neg_rem;
    assign neg_av  = (~r_av + DW'(1)) & r_mask;
    assign neg_bv  = (~r_bv + DW'(1)) & r_mask;
    assign neg_rem = (~r_rem + DW'(1)) & r_mask;

    logic shamt_big;
    assign shamt_big = (r_bv >= DW'(r_w));

    // a finished result moves out once the output register is free or leaving
    assign load_out = (r_state == S_DONE) && (!r_ovalid || !i_stall);

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_result_value      = r_out_rv;
    assign o_result_unknown    = r_out_ru;
    assign o_remainder_value   = r_out_qv;
    assign o_remainder_unknown = r_out_qu;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op   <= i_opcode;
                        r_fs   <= i_four_state;
                        r_sg   <= i_is_signed;
                        r_w    <= CW'(w_in);
                        r_mask <= m_in;
                        r_av   <= i_a_value[DW-1:0] & m_in;
                        r_au   <= i_a_unknown[DW-1:0] & m_in;
                        r_bv   <= i_b_value[DW-1:0] & m_in;
                        r_bu   <= i_b_unknown[DW-1:0] & m_in;
                        // clear the working registers for the new item; r_acu takes operand a's unknown word
                        r_rv   <= '0;
                        r_ru   <= '0;
                        r_qv   <= '0;
                        r_qu   <= '0;
                        r_cnt  <= '0;
                        r_acc  <= '0;
                        r_acu  <= i_a_unknown[DW-1:0] & m_in;
                        r_rem  <= '0;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    unique case (r_op) inside
                        OP_ADD, OP_SUB: begin
                            if ((r_au | r_bu) != '0) r_ru <= 64'(r_mask);
                            else r_rv <= 64'(add_s & r_mask);
                            r_state <= S_DONE;
                        end
                        OP_MUL: begin
                            if ((r_au | r_bu) != '0) begin
                                r_ru <= 64'(r_mask);
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_MUL;
                            end
                        end
                        OP_DIV: begin
                            if ((r_au | r_bu) != '0 || r_bv == '0) begin
                                r_ru <= 64'(r_mask);
                                r_qu <= 64'(r_mask);
                                r_state <= S_DONE;
                            end else begin
                                r_an <= r_sg && ((r_av & top_bit) != '0);
                                r_bn <= r_sg && ((r_bv & top_bit) != '0);
                                // dividend left-aligned so its top bit leads
                                r_acc <= (r_sg && ((r_av & top_bit) != '0) ? neg_av : r_av)
                                         << (CW'(DW) - r_w);
                                r_bv <= (r_sg && ((r_bv & top_bit) != '0)) ? neg_bv : r_bv;
                                r_state <= S_DIV;
                            end
                        end
                        OP_AND, OP_OR, OP_XOR: begin
                            r_rv <= 64'(bw_v & r_mask);
                            r_ru <= 64'(bw_u & r_mask);
                            r_state <= S_DONE;
                        end
                        OP_SHL, OP_LSHR, OP_ASHR: begin
                            if (r_bu != '0) begin
                                r_ru <= 64'(r_mask);
                                r_state <= S_DONE;
                            end else if (shamt_big) begin
                                // shl and lshr give zero, ashr fills with the top bit
                                if (r_op == OP_ASHR) begin
                                    r_rv <= ((r_av & top_bit) != '0) ? 64'(r_mask) : '0;
                                    r_ru <= ((r_au & top_bit) != '0) ? 64'(r_mask) : '0;
                                end
                                r_state <= S_DONE;
                            end else begin
                                r_acc <= r_av;
                                r_state <= S_SHIFT;
                            end
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_MUL: begin
                    // shift-add from the top multiplier bit down
                    if (r_cnt == r_w - CW'(1)) begin
                        r_rv <= 64'(mul_next & r_mask);
                        r_state <= S_DONE;
                    end else begin
                        r_acc <= mul_next << 1;
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_DIV: begin
                    r_acc <= {r_acc[DW-2:0], ~d_trial[DW]};
                    r_rem <= d_trial[DW] ? d_rsh : d_trial[DW-1:0];
                    if (r_cnt == r_w - CW'(1)) r_state <= S_FIX;
                    r_cnt <= r_cnt + CW'(1);
                end
                S_FIX: begin
                    r_rv <= 64'(((r_an != r_bn) ? add_s : r_acc) & r_mask);
                    r_qv <= 64'((r_an ? neg_rem : r_rem) & r_mask);
                    r_state <= S_DONE;
                end
                S_SHIFT: begin
                    if (DW'(r_cnt) == r_bv) begin
                        r_rv <= 64'(r_acc & r_mask);
                        r_ru <= 64'(r_acu & r_mask);
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                        unique case (r_op)
                            OP_SHL: begin
                                r_acc <= r_acc << 1;
                                r_acu <= r_acu << 1;
                            end
                            OP_LSHR: begin
                                r_acc <= r_acc >> 1;
                                r_acu <= r_acu >> 1;
                            end
                            default: begin
                                r_acc <= (r_acc >> 1) | (r_acc & top_bit);
                                r_acu <= (r_acu >> 1) | (r_acu & top_bit);
                            end
                        endcase
                    end
                end
                S_DONE: begin
                    if (load_out) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase

            // output register: load a finished item, or empty once taken
            if (load_out) begin
                r_ovalid <= 1'b1;
                r_out_rv <= r_rv;
                r_out_ru <= r_ru;
                r_out_qv <= r_qv;
                r_out_qu <= r_qu;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    `FSA_ASSERT_IMP(a_busy_stall, (r_state != S_IDLE), o_stall)
    `FSA_ASSERT_NEXT(a_hold_done, (o_valid && i_stall), o_valid && $stable(o_result_value))
    `FSA_ASSERT_NEXT(a_accept_prep, (i_valid && !o_stall), r_state == S_PREP)
endmodule

// ===== test/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import fsa_pkg::*;

    localparam int unsigned DW = 64;

    // operation item as sent to the block
    typedef struct packed {
        logic [3:0]  opcode;
        logic [6:0]  op_width;
        logic        four_state;
        logic        is_signed;
        logic [63:0] a_value;
        logic [63:0] a_unknown;
        logic [63:0] b_value;
        logic [63:0] b_unknown;
    } t_alu_op;

    // result item as it leaves the block
    typedef struct packed {
        logic [63:0] result_value;
        logic [63:0] result_unknown;
        logic [63:0] remainder_value;
        logic [63:0] remainder_unknown;
    } t_alu_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [3:0]  i_opcode;
    logic [6:0]  i_op_width;
    logic        i_four_state;
    logic        i_is_signed;
    logic [63:0] i_a_value;
    logic [63:0] i_a_unknown;
    logic [63:0] i_b_value;
    logic [63:0] i_b_unknown;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_result_value;
    logic [63:0] o_result_unknown;
    logic [63:0] o_remainder_value;
    logic [63:0] o_remainder_unknown;

    t_alu_res expected_results[$];
    int       mismatches;

    four_state_integer_alu #(.DATA_WIDTH(DW)) dut (.*);

    // free-running clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #40ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [63:0] wmask(int unsigned w);
        return w >= 64 ? '1 : ((64'd1 << w) - 64'd1);
    endfunction

    function automatic logic [63:0] negate(logic [63:0] x, logic [63:0] m);
        return (~x + 64'd1) & m;
    endfunction

    // computes the expected result item for one operation
    function automatic t_alu_res alu_predict(t_alu_op op);
        t_alu_res    r;
        int unsigned w;
        logic [63:0] m, av, au, bv, bu, top, na, nd, q, rem, fill, ak, bk, k0, k1;
        logic        anyx, an, bn, sv, su, over;
        r = '0;
        w = {25'd0, op.op_width};
        if (w < 1) w = 1;
        if (w > DW) w = DW;
        m = wmask(w);
        av = op.a_value & m;
        au = op.a_unknown & m;
        bv = op.b_value & m;
        bu = op.b_unknown & m;
        anyx = (au | bu) != 0;
        top = 64'd1 << (w - 1);
        case (op.opcode)
            OP_ADD, OP_SUB, OP_MUL: begin
                if (anyx) r.result_unknown = m;
                else if (op.opcode == OP_ADD) r.result_value = (av + bv) & m;
                else if (op.opcode == OP_SUB) r.result_value = (av + negate(bv, m)) & m;
                else r.result_value = (av * bv) & m;
            end
            OP_DIV: begin
                if (anyx || bv == 0) begin
                    r.result_unknown = m;
                    r.remainder_unknown = m;
                end else begin
                    an = op.is_signed && (av & top) != 0;
                    bn = op.is_signed && (bv & top) != 0;
                    na = an ? negate(av, m) : av;
                    nd = bn ? negate(bv, m) : bv;
                    q = na / nd;
                    rem = na % nd;
                    r.result_value = (an != bn) ? negate(q, m) : q;
                    r.remainder_value = an ? negate(rem, m) : rem;
                end
            end
            OP_AND, OP_OR, OP_XOR: begin
                if (!op.four_state) begin
                    r.result_value = op.opcode == OP_AND ? (av & bv) :
                                     op.opcode == OP_OR ? (av | bv) : (av ^ bv);
                end else begin
                    ak = ~au;
                    bk = ~bu;
                    if (op.opcode == OP_AND) begin
                        k0 = (~av & ak) | (~bv & bk);
                        k1 = (av & ak) & (bv & bk);
                        r.result_value = k1;
                        r.result_unknown = ~(k0 | k1);
                    end else if (op.opcode == OP_OR) begin
                        k1 = (av & ak) | (bv & bk);
                        k0 = (~av & ak) & (~bv & bk);
                        r.result_value = k1;
                        r.result_unknown = ~(k0 | k1);
                    end else begin
                        r.result_unknown = au | bu;
                        r.result_value = (av ^ bv) & ~(au | bu);
                    end
                end
            end
            OP_SHL, OP_LSHR, OP_ASHR: begin
                if (bu != 0) begin
                    r.result_unknown = m;
                end else begin
                    over = bv >= w;
                    if (op.opcode == OP_SHL) begin
                        if (!over) begin
                            r.result_value = av << bv;
                            r.result_unknown = au << bv;
                        end
                    end else if (op.opcode == OP_LSHR) begin
                        if (!over) begin
                            r.result_value = av >> bv;
                            r.result_unknown = au >> bv;
                        end
                    end else begin
                        sv = (av & top) != 0;
                        su = (au & top) != 0;
                        if (over) begin
                            r.result_value = sv ? m : 64'd0;
                            r.result_unknown = su ? m : 64'd0;
                        end else begin
                            fill = m & ~(m >> bv);
                            r.result_value = (av >> bv) | (sv ? fill : 64'd0);
                            r.result_unknown = (au >> bv) | (su ? fill : 64'd0);
                        end
                    end
                end
            end
            default: r = '0;
        endcase
        r.result_value &= m;
        r.result_unknown &= m;
        r.remainder_value &= m;
        r.remainder_unknown &= m;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // sends one item after a random gap and queues its prediction
    task automatic send_op(t_alu_op op);
        int gap;
        gap = int'($urandom_range(19));
        if ($urandom_range(3) == 0) gap = 0;
        // valid stays up straight into a back-to-back item
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_opcode     <= op.opcode;
        i_op_width   <= op.op_width;
        i_four_state <= op.four_state;
        i_is_signed  <= op.is_signed;
        i_a_value    <= op.a_value;
        i_a_unknown  <= op.a_unknown;
        i_b_value    <= op.b_value;
        i_b_unknown  <= op.b_unknown;
        // wait for the edge that takes the item
        do @(posedge i_clk); while (o_stall);
        expected_results.push_back(alu_predict(op));
    endtask

    task automatic send_fields(logic [3:0] opc, int w, bit fs, bit sg, logic [63:0] av,
                               logic [63:0] au, logic [63:0] bv, logic [63:0] bu);
        t_alu_op op;
        op = '{opc, w[6:0], fs, sg, av, au, bv, bu};
        send_op(op);
    endtask

    // directed: extremes of width, every operation, each special case
    task automatic test_directed();
        logic [3:0] opc;
        for (int k = 0; k < 10; k++) begin
            opc = k[3:0];
            send_fields(opc, 64, 1, 1, '1, 64'd0, '1, 64'd0);
        end
        send_fields(OP_ADD, 0, 0, 0, '1, 64'd0, 64'd1, 64'd0);     // width zero acts as one
        send_fields(OP_ADD, 127, 0, 0, '1, 64'd0, 64'd1, 64'd0);   // width above maximum
        send_fields(OP_ADD, 8, 0, 0, 64'h1, 64'h1, 64'h1, 64'd0);  // unknown in arithmetic
        send_fields(OP_DIV, 16, 0, 1, 64'h1234, 64'd0, 64'd0, 64'd0); // divide by zero
        send_fields(OP_DIV, 8, 0, 1, 64'h80, 64'd0, 64'hff, 64'd0);   // most negative by -1
        send_fields(OP_DIV, 8, 0, 1, 64'hf9, 64'd0, 64'h02, 64'd0);   // negative dividend
        send_fields(OP_DIV, 64, 0, 0, '1, 64'd0, 64'd3, 64'd0);
        send_fields(OP_AND, 8, 1, 0, 64'h0f, 64'h33, 64'h55, 64'h0f);
        send_fields(OP_OR, 8, 1, 0, 64'h0f, 64'h33, 64'h55, 64'h0f);
        send_fields(OP_XOR, 8, 0, 0, 64'h0f, 64'h33, 64'h55, 64'h0f); // two-state ignores x
        send_fields(OP_SHL, 8, 0, 0, 64'h81, 64'h01, 64'd1, 64'h01);  // unknown amount
        send_fields(OP_ASHR, 8, 0, 0, 64'h81, 64'h80, 64'd9, 64'd0);  // amount over width
        send_fields(OP_ASHR, 8, 0, 0, 64'h81, 64'h80, 64'd3, 64'd0);
        send_fields(OP_LSHR, 1, 0, 0, 64'h1, 64'h1, 64'd0, 64'd0);
        send_fields(4'd15, 32, 1, 1, '1, '1, '1, '1);                 // undefined opcode
    endtask

    // random: mostly small widths, mostly known operands
    task automatic test_random(int count);
        t_alu_op     op;
        logic [63:0] m;
        int          w;
        for (int n = 0; n < count; n++) begin
            op.opcode = ($urandom_range(15) == 0) ? 4'($urandom_range(15))
                                                  : 4'($urandom_range(9));
            case ($urandom_range(9))
                0: w = 64;
                1: w = int'($urandom_range(127));
                2, 3: w = int'($urandom_range(64, 1));
                default: w = int'($urandom_range(16, 1));
            endcase
            op.op_width = 7'(w);
            op.four_state = 1'($urandom_range(1));
            op.is_signed = 1'($urandom_range(1));
            op.a_value = rand64();
            op.b_value = rand64();
            m = wmask(w == 0 ? 1 : (w > 64 ? 64 : w));
            op.a_unknown = ($urandom_range(3) == 0) ? rand64() & rand64() : 64'd0;
            op.b_unknown = ($urandom_range(3) == 0) ? rand64() & rand64() : 64'd0;
            if ($urandom_range(4) == 0) op.a_unknown = rand64();
            // shifts mostly in range, occasionally a zero divisor
            if (op.opcode inside {OP_SHL, OP_LSHR, OP_ASHR} && $urandom_range(3) != 0)
                op.b_value = 64'($urandom_range(w + 1));
            if (op.opcode == OP_DIV && $urandom_range(15) == 0) op.b_value = 64'd0;
            if (op.opcode == OP_DIV && $urandom_range(1) == 0) op.b_value &= m >> 2;
            send_op(op);
        end
    endtask

    // random output stall, with stretches of none
    initial begin
        int stretch;
        i_stall = 1'b0;
        forever begin
            stretch = int'($urandom_range(19));
            if ($urandom_range(3) == 0) begin
                repeat (20) @(posedge i_clk);
            end else begin
                if (stretch != 0) begin
                    i_stall <= 1'b1;
                    repeat (stretch) @(posedge i_clk);
                    i_stall <= 1'b0;
                end
                @(posedge i_clk);
            end
        end
    end

    // result checker against the oldest prediction
    always @(posedge i_clk) begin
        t_alu_res got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_result_value, o_result_unknown, o_remainder_value, o_remainder_unknown};
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item %h", got);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h %h %h %h, got %h %h %h %h",
                                 want.result_value, want.result_unknown,
                                 want.remainder_value, want.remainder_unknown,
                                 got.result_value, got.result_unknown,
                                 got.remainder_value, got.remainder_unknown);
                end
            end
        end
    end

    initial begin
        mismatches   = 0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_opcode     = '0;
        i_op_width   = 7'd1;
        i_four_state = 1'b0;
        i_is_signed  = 1'b0;
        i_a_value    = '0;
        i_a_unknown  = '0;
        i_b_value    = '0;
        i_b_unknown  = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(750);
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
